// ===== sv/hmct_pkg.sv =====
package hmct_pkg;

	// Field widths fixed by the port list
	localparam int unsigned KEY_W   = 63;
	localparam int unsigned TAG_W   = 64;
	localparam int unsigned SLOT_W  = 22;
	localparam int unsigned VAL_W   = 64;
	localparam int unsigned CNT_W   = 27;
	localparam int unsigned STAT_W  = 3;
	localparam int unsigned HALF_W  = 32;

	localparam int unsigned LOG2_SLOTS_DEFAULT = 22;
	localparam logic [CNT_W-1:0] LIMIT_RESET = 27'd3355440;

	// Mixer multipliers
	localparam logic [TAG_W-1:0] MIX_MUL_A = 64'hbf58476d1ce4e5b9;
	localparam logic [TAG_W-1:0] MIX_MUL_B = 64'h94d049bb133111eb;

	typedef enum logic [STAT_W-1:0] {
		STAT_HIT      = 3'd0,
		STAT_CLAIMED  = 3'd1,
		STAT_PENDING  = 3'd2,
		STAT_LOAD     = 3'd3,
		STAT_FULL     = 3'd4,
		STAT_BAD_KEY  = 3'd5,
		STAT_BAD_PUB  = 3'd6
	} status_t;

	// Step of the shared multiplier within one 64-bit product
	typedef enum logic [1:0] {
		MS_LL = 2'd0,
		MS_LH = 2'd1,
		MS_HL = 2'd2,
		MS_SUM = 2'd3
	} mstep_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_MUL,
		S_FOLD,
		S_PROBE,
		S_PUB
	} state_t;

endpackage

// ===== sv/hash_memo_claim_table_core.sv =====
// Channel   | Signals                                         | Handshake
// ----------+-------------------------------------------------+--------------------------------
// request   | req_type key slot value_in_low value_in_high    | taken when start && !busy
// result    | status slot_out value_low value_high            | done strobe, one cycle, no stall
// config    | cfg_data (occupancy_limit)                      | taken when cfg_valid && cfg_ready
//
// A get request runs from acceptance to the next acceptance through two 64-bit multiplies of
// four steps each on the one shared 32x32 multiplier, two fold steps, then one probe of the tag
// memory read port per cycle. A publish makes one tag read; a zero key or out-of-range publish
// slot is refused without a tag read. After reset the tag memory is swept to zero, one slot a
// cycle with busy high; configuration is taken throughout. Results cannot stall: done pulses
// once per request.
module hash_memo_claim_table_core #(
	parameter int unsigned LOG2_SLOTS = hmct_pkg::LOG2_SLOTS_DEFAULT
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// request
	input  logic                          start,
	output logic                          busy,
	input  logic                          req_type,
	input  logic [hmct_pkg::KEY_W-1:0]    key,
	input  logic [hmct_pkg::SLOT_W-1:0]   slot,
	input  logic [hmct_pkg::VAL_W-1:0]    value_in_low,
	input  logic [hmct_pkg::VAL_W-1:0]    value_in_high,
	// result
	output logic                          done,
	output logic [hmct_pkg::STAT_W-1:0]   status,
	output logic [hmct_pkg::SLOT_W-1:0]   slot_out,
	output logic [hmct_pkg::VAL_W-1:0]    value_low,
	output logic [hmct_pkg::VAL_W-1:0]    value_high,
	// configuration
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [hmct_pkg::CNT_W-1:0]    cfg_data
);

	localparam int unsigned AddrW     = LOG2_SLOTS;
	localparam int unsigned SlotCount = 2 ** LOG2_SLOTS;
	localparam int unsigned SlotExtW  =
		(LOG2_SLOTS > hmct_pkg::SLOT_W) ? LOG2_SLOTS : hmct_pkg::SLOT_W;
	localparam int unsigned TagW      = hmct_pkg::TAG_W;
	localparam int unsigned HalfW     = hmct_pkg::HALF_W;
	localparam int unsigned ValW      = hmct_pkg::VAL_W;

	// Tag store: bit 63 is the done flag, bits 62..0 the key; zero means empty.
	logic [TagW-1:0]   tag_mem [SlotCount];
	// Value store: low half in [63:0], high half in [127:64]; never cleared.
	logic [2*ValW-1:0] val_mem [SlotCount];

	hmct_pkg::state_t state_q, state_d;
	hmct_pkg::mstep_t mstep_q;

	logic                        second_q;
	logic [AddrW-1:0]            clr_q;
	logic [AddrW-1:0]            pos_q;
	logic [AddrW-1:0]            seen_q;
	logic [hmct_pkg::CNT_W-1:0]  occ_q;
	logic [hmct_pkg::CNT_W-1:0]  limit_q;

	logic [hmct_pkg::KEY_W-1:0]  key_q;
	logic [hmct_pkg::SLOT_W-1:0] slot_q;
	logic [2*ValW-1:0]           val_in_q;
	logic [TagW-1:0]             x_q;
	logic [TagW-1:0]             acc_q;
	logic [TagW-1:0]             prod_q;

	logic [TagW-1:0]             tag_rd_q;
	logic [2*ValW-1:0]           val_rd_q;

	logic                        done_q;
	logic [hmct_pkg::STAT_W-1:0] status_q;
	logic [hmct_pkg::SLOT_W-1:0] slot_out_q;
	logic [ValW-1:0]             value_low_q;
	logic [ValW-1:0]             value_high_q;

	// Request decode
	logic                  accept;
	logic                  key_zero;
	logic [SlotExtW-1:0]   slot_ext;
	logic                  slot_ok;
	logic [AddrW-1:0]      slot_addr;
	logic [TagW-1:0]       key_ext;
	logic [TagW-1:0]       key_mix;

	// Shared multiplier
	logic [HalfW-1:0]      mul_a;
	logic [HalfW-1:0]      mul_b;
	logic [TagW-1:0]       mul_c;
	logic [TagW-1:0]       prod_d;
	logic [TagW-1:0]       hash_fold;
	logic [TagW-1:0]       acc_fold;

	// Probe decode
	logic                  probe_match;
	logic                  probe_empty;
	logic                  probe_last;
	logic                  over_limit;
	logic                  pub_ok;
	logic [AddrW-1:0]      pos_next;

	// Memory ports and response
	logic                  tag_re;
	logic [AddrW-1:0]      tag_raddr;
	logic                  tag_we;
	logic [AddrW-1:0]      tag_waddr;
	logic [TagW-1:0]       tag_wdata;
	logic                  val_we;
	logic                  claim;
	logic                  resp_en;
	hmct_pkg::status_t     resp_status;
	logic [hmct_pkg::SLOT_W-1:0] resp_slot;
	logic [ValW-1:0]       resp_lo;
	logic [ValW-1:0]       resp_hi;

	assign busy      = (state_q != hmct_pkg::S_IDLE);
	assign accept    = start && !busy;
	assign cfg_ready = 1'b1;

	assign key_zero  = (key == '0);
	assign slot_ext  = SlotExtW'(slot);
	assign slot_ok   = ((slot_ext >> LOG2_SLOTS) == '0);
	assign slot_addr = slot_ext[AddrW-1:0];
	assign key_ext   = {1'b0, key};
	assign key_mix   = key_ext ^ (key_ext >> 30);

	// Low 64 bits of x * c from three 32x32 partial products; the high*high term drops out.
	assign mul_c  = second_q ? hmct_pkg::MIX_MUL_B : hmct_pkg::MIX_MUL_A;
	assign mul_a  = (mstep_q == hmct_pkg::MS_HL) ? x_q[TagW-1:HalfW] : x_q[HalfW-1:0];
	assign mul_b  = (mstep_q == hmct_pkg::MS_LH) ? mul_c[TagW-1:HalfW] : mul_c[HalfW-1:0];
	assign prod_d = {{HalfW{1'b0}}, mul_a} * {{HalfW{1'b0}}, mul_b};

	assign acc_fold  = acc_q ^ (acc_q >> 27);
	assign hash_fold = acc_q ^ (acc_q >> 31);

	assign probe_match = (tag_rd_q[TagW-2:0] == key_q);
	assign probe_empty = (tag_rd_q == '0);
	assign probe_last  = (&seen_q);
	assign over_limit  = (occ_q >= limit_q);
	assign pos_next    = pos_q + AddrW'(1);
	assign pub_ok      = (tag_rd_q == {1'b0, key_q});

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			hmct_pkg::S_CLEAR: begin
				if (&clr_q) begin
					state_d = hmct_pkg::S_IDLE;
				end
			end
			hmct_pkg::S_IDLE: begin
				if (accept && !key_zero) begin
					if (req_type) begin
						if (slot_ok) begin
							state_d = hmct_pkg::S_PUB;
						end
					end else begin
						state_d = hmct_pkg::S_MUL;
					end
				end
			end
			hmct_pkg::S_MUL: begin
				if (mstep_q == hmct_pkg::MS_SUM) begin
					state_d = hmct_pkg::S_FOLD;
				end
			end
			hmct_pkg::S_FOLD: begin
				state_d = second_q ? hmct_pkg::S_PROBE : hmct_pkg::S_MUL;
			end
			hmct_pkg::S_PROBE: begin
				if (probe_match || probe_empty || probe_last) begin
					state_d = hmct_pkg::S_IDLE;
				end
			end
			hmct_pkg::S_PUB: begin
				state_d = hmct_pkg::S_IDLE;
			end
			default: begin
				state_d = hmct_pkg::S_IDLE;
			end
		endcase
	end

	// Memory controls and response
	always_comb begin
		tag_re      = 1'b0;
		tag_raddr   = pos_q;
		tag_we      = 1'b0;
		tag_waddr   = pos_q;
		tag_wdata   = {1'b0, key_q};
		val_we      = 1'b0;
		claim       = 1'b0;
		resp_en     = 1'b0;
		resp_status = hmct_pkg::STAT_HIT;
		resp_slot   = '0;
		resp_lo     = '0;
		resp_hi     = '0;
		unique case (state_q)
			hmct_pkg::S_CLEAR: begin
				tag_we    = 1'b1;
				tag_waddr = clr_q;
				tag_wdata = '0;
			end
			hmct_pkg::S_IDLE: begin
				if (accept) begin
					if (key_zero) begin
						resp_en     = 1'b1;
						resp_status = req_type ? hmct_pkg::STAT_BAD_PUB
						                       : hmct_pkg::STAT_BAD_KEY;
					end else if (req_type) begin
						if (slot_ok) begin
							tag_re    = 1'b1;
							tag_raddr = slot_addr;
						end else begin
							resp_en     = 1'b1;
							resp_status = hmct_pkg::STAT_BAD_PUB;
						end
					end
				end
			end
			hmct_pkg::S_MUL: begin
			end
			hmct_pkg::S_FOLD: begin
				// Issue the home slot read straight from the finished hash
				if (second_q) begin
					tag_re    = 1'b1;
					tag_raddr = hash_fold[AddrW-1:0];
				end
			end
			hmct_pkg::S_PROBE: begin
				priority if (probe_match) begin
					resp_en   = 1'b1;
					resp_slot = hmct_pkg::SLOT_W'(pos_q);
					if (tag_rd_q[TagW-1]) begin
						resp_status = hmct_pkg::STAT_HIT;
						resp_lo     = val_rd_q[ValW-1:0];
						resp_hi     = val_rd_q[2*ValW-1:ValW];
					end else begin
						resp_status = hmct_pkg::STAT_PENDING;
					end
				end else if (probe_empty) begin
					resp_en = 1'b1;
					if (over_limit) begin
						resp_status = hmct_pkg::STAT_LOAD;
					end else begin
						resp_status = hmct_pkg::STAT_CLAIMED;
						resp_slot   = hmct_pkg::SLOT_W'(pos_q);
						tag_we      = 1'b1;
						claim       = 1'b1;
					end
				end else if (probe_last) begin
					resp_en     = 1'b1;
					resp_status = hmct_pkg::STAT_FULL;
				end else begin
					tag_re    = 1'b1;
					tag_raddr = pos_next;
				end
			end
			hmct_pkg::S_PUB: begin
				resp_en = 1'b1;
				if (pub_ok) begin
					resp_status = hmct_pkg::STAT_HIT;
					resp_slot   = slot_q;
					tag_we      = 1'b1;
					tag_waddr   = pos_q;
					tag_wdata   = {1'b1, key_q};
					val_we      = 1'b1;
				end else begin
					resp_status = hmct_pkg::STAT_BAD_PUB;
				end
			end
			default: begin
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= hmct_pkg::S_CLEAR;
			mstep_q  <= hmct_pkg::MS_LL;
			second_q <= 1'b0;
			clr_q    <= '0;
			seen_q   <= '0;
			occ_q    <= '0;
			limit_q  <= hmct_pkg::LIMIT_RESET;
			done_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= resp_en;
			if (cfg_valid && cfg_ready) begin
				limit_q <= cfg_data;
			end
			if (state_q == hmct_pkg::S_CLEAR) begin
				clr_q <= clr_q + AddrW'(1);
			end
			if (claim) begin
				occ_q <= occ_q + hmct_pkg::CNT_W'(1);
			end
			unique case (state_q)
				hmct_pkg::S_IDLE: begin
					mstep_q  <= hmct_pkg::MS_LL;
					second_q <= 1'b0;
				end
				hmct_pkg::S_MUL: begin
					mstep_q <= hmct_pkg::mstep_t'(mstep_q + 2'd1);
				end
				hmct_pkg::S_FOLD: begin
					mstep_q  <= hmct_pkg::MS_LL;
					second_q <= 1'b1;
					seen_q   <= '0;
				end
				hmct_pkg::S_PROBE: begin
					seen_q <= seen_q + AddrW'(1);
				end
				default: begin
				end
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			key_q    <= key;
			slot_q   <= slot;
			val_in_q <= {value_in_high, value_in_low};
			x_q      <= key_mix;
			pos_q    <= slot_addr;
		end
		unique case (state_q)
			hmct_pkg::S_MUL: begin
				prod_q <= prod_d;
				unique case (mstep_q)
					hmct_pkg::MS_LL: begin
					end
					hmct_pkg::MS_LH: begin
						acc_q <= prod_q;
					end
					hmct_pkg::MS_HL, hmct_pkg::MS_SUM: begin
						acc_q[TagW-1:HalfW] <= acc_q[TagW-1:HalfW] + prod_q[HalfW-1:0];
					end
					default: begin
					end
				endcase
			end
			hmct_pkg::S_FOLD: begin
				// Fold between the multiplies; after the second, latch the home slot
				if (second_q) begin
					pos_q <= hash_fold[AddrW-1:0];
				end else begin
					x_q <= acc_fold;
				end
			end
			hmct_pkg::S_PROBE: begin
				if (!probe_match && !probe_empty) begin
					pos_q <= pos_next;
				end
			end
			default: begin
			end
		endcase
		if (resp_en) begin
			status_q     <= resp_status;
			slot_out_q   <= resp_slot;
			value_low_q  <= resp_lo;
			value_high_q <= resp_hi;
		end
	end

	// Tag memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (tag_we) begin
			tag_mem[tag_waddr] <= tag_wdata;
		end
		if (tag_re) begin
			tag_rd_q <= tag_mem[tag_raddr];
		end
	end

	// Value memory: read alongside every tag read, written by publish
	always_ff @(posedge clk) begin
		if (val_we) begin
			val_mem[pos_q] <= val_in_q;
		end
		if (tag_re) begin
			val_rd_q <= val_mem[tag_raddr];
		end
	end

	assign done       = done_q;
	assign status     = status_q;
	assign slot_out   = slot_out_q;
	assign value_low  = value_low_q;
	assign value_high = value_high_q;

	// A value is stored only together with a tag that carries the done flag
	a_val_with_done: assert property (@(posedge clk) disable iff (!arst_n)
		val_we |-> (tag_we && tag_wdata[TagW-1]))
		else $error("value write without completing tag write");

	// The occupancy count moves only on a claim
	a_occ_on_claim: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(occ_q) |-> $past(claim))
		else $error("occupancy count changed without a claim");

	// An accepted request either answers at once or starts work
	a_accept_moves: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (done_q || state_q == hmct_pkg::S_MUL || state_q == hmct_pkg::S_PUB))
		else $error("accepted request neither answered nor started");

	// Probing steps one slot at a time
	a_probe_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == hmct_pkg::S_PROBE && $past(state_q) == hmct_pkg::S_PROBE)
		|-> (pos_q == $past(pos_q) + AddrW'(1)))
		else $error("probe position skipped");

	// No tag write while waiting for a request
	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == hmct_pkg::S_IDLE) |-> !tag_we)
		else $error("tag write while idle");

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps

module tb;
	import hmct_pkg::*;

	localparam int unsigned LOG2 = LOG2_SLOTS_DEFAULT;
	localparam int unsigned SLOTS = 1 << LOG2;
	localparam logic [63:0] SLOT_MASK64 = (64'd1 << LOG2) - 64'd1;
	localparam logic [CNT_W-1:0] LIMIT_MAX = '1;
	localparam logic [CNT_W-1:0] LIMIT_HIGH = 27'd67108864;
	// Cycles to let pass once nothing is outstanding: covers a long probe chain
	localparam int SETTLE = 64;
	// Clearing sweep plus a slow run of every request, then three times over
	localparam int CYCLE_LIMIT = 3 * (SLOTS + 2000 * 130);

	// One request as the sender presents it
	typedef struct packed {
		logic              is_publish;
		logic [KEY_W-1:0]  key;
		logic [SLOT_W-1:0] slot;
		logic [VAL_W-1:0]  lo;
		logic [VAL_W-1:0]  hi;
	} request_t;

	// One answer as the block reports it
	typedef struct packed {
		status_t           status;
		logic [SLOT_W-1:0] slot;
		logic [VAL_W-1:0]  lo;
		logic [VAL_W-1:0]  hi;
	} answer_t;

	// Shadow of the memo table: predicts each answer and matches the block against it
	class memo_tracker;
		logic [TAG_W-1:0]   tag_of [int unsigned];
		logic [2*VAL_W-1:0] value_of [int unsigned];
		logic [CNT_W-1:0]   claimed;
		logic [CNT_W-1:0]   limit;
		answer_t            answers_due [$];
		int                 errors;
		int                 by_status [8];

		function new();
			claimed = '0;
			limit = LIMIT_RESET;
			errors = 0;
			foreach (by_status[i]) by_status[i] = 0;
		endfunction

		function logic [63:0] mix_key(logic [63:0] v);
			v = v ^ (v >> 30);
			v = v * MIX_MUL_A;
			v = v ^ (v >> 27);
			v = v * MIX_MUL_B;
			return v ^ (v >> 31);
		endfunction

		function logic [TAG_W-1:0] tag_at(int unsigned pos);
			return tag_of.exists(pos) ? tag_of[pos] : '0;
		endfunction

		// Work out the answer to an accepted request and queue it
		function answer_t note_request(request_t r);
			answer_t          a;
			logic [TAG_W-1:0] t;
			int unsigned      pos;
			int unsigned      n;
			bit               settled;
			a.status = STAT_BAD_PUB;
			a.slot = '0;
			a.lo = '0;
			a.hi = '0;
			if (r.is_publish) begin
				// Only a pending slot held by this very key takes a value
				if (r.key != '0 && r.slot < SLOTS && tag_at(r.slot) == {1'b0, r.key}) begin
					value_of[r.slot] = {r.hi, r.lo};
					tag_of[r.slot] = {1'b1, r.key};
					a.status = STAT_HIT;
					a.slot = r.slot;
				end
			end else if (r.key == '0) begin
				a.status = STAT_BAD_KEY;
			end else begin
				a.status = STAT_FULL;
				pos = int'(mix_key({1'b0, r.key}) & SLOT_MASK64);
				settled = 1'b0;
				for (n = 0; n < SLOTS && !settled; n++) begin
					t = tag_at(pos);
					if (t[KEY_W-1:0] == r.key) begin
						settled = 1'b1;
						a.slot = pos[SLOT_W-1:0];
						if (t[TAG_W-1]) begin
							a.status = STAT_HIT;
							{a.hi, a.lo} = value_of[pos];
						end else begin
							a.status = STAT_PENDING;
						end
					end else if (t == '0) begin
						settled = 1'b1;
						if (claimed >= limit) begin
							a.status = STAT_LOAD;
						end else begin
							tag_of[pos] = {1'b0, r.key};
							claimed = claimed + 1'b1;
							a.status = STAT_CLAIMED;
							a.slot = pos[SLOT_W-1:0];
						end
					end else begin
						pos = (pos + 1) & (SLOTS - 1);
					end
				end
			end
			answers_due.push_back(a);
			return a;
		endfunction

		// Match one answer from the block against the oldest one due
		function void check_answer(answer_t got);
			answer_t want;
			if (answers_due.size() == 0) begin
				$error("answer with no request outstanding: status %0d slot_out %0d",
					got.status, got.slot);
				errors++;
			end else begin
				want = answers_due.pop_front();
				by_status[int'(want.status)]++;
				if (got.status !== want.status) begin
					$error("status: expected %0d, actual %0d", want.status, got.status);
					errors++;
				end
				if (got.slot !== want.slot) begin
					$error("slot_out: expected %0d, actual %0d", want.slot, got.slot);
					errors++;
				end
				if (got.lo !== want.lo) begin
					$error("value_low: expected %h, actual %h", want.lo, got.lo);
					errors++;
				end
				if (got.hi !== want.hi) begin
					$error("value_high: expected %h, actual %h", want.hi, got.hi);
					errors++;
				end
			end
		endfunction
	endclass

	logic              clk;
	logic              arst_n;
	logic              start;
	logic              busy;
	logic              req_type;
	logic [KEY_W-1:0]  key;
	logic [SLOT_W-1:0] slot;
	logic [VAL_W-1:0]  value_in_low;
	logic [VAL_W-1:0]  value_in_high;
	logic              done;
	logic [STAT_W-1:0] status;
	logic [SLOT_W-1:0] slot_out;
	logic [VAL_W-1:0]  value_low;
	logic [VAL_W-1:0]  value_high;
	logic              cfg_valid;
	logic              cfg_ready;
	logic [CNT_W-1:0]  cfg_data;

	memo_tracker sb;
	answer_t     last_answer;
	int          cycles;

	// Keys the block has handed out, still pending and already complete
	logic [KEY_W-1:0]  open_key [$];
	logic [SLOT_W-1:0] open_slot [$];
	logic [KEY_W-1:0]  done_key [$];
	logic [SLOT_W-1:0] done_slot [$];

	// Home slots that crafted keys crowd onto, so that probe chains grow long
	int unsigned hot [8];
	logic [63:0] inv_a;
	logic [63:0] inv_b;

	hash_memo_claim_table_core #(
		.LOG2_SLOTS(LOG2)
	) u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.req_type     (req_type),
		.key          (key),
		.slot         (slot),
		.value_in_low (value_in_low),
		.value_in_high(value_in_high),
		.done         (done),
		.status       (status),
		.slot_out     (slot_out),
		.value_low    (value_low),
		.value_high   (value_high),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Guard against a hang: give up well past the slowest correct run
	initial cycles = 0;
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timed out after %0d cycles", cycles);
			$display("FAILED: results differ");
			$finish;
		end
	end

	// Sample the answer on the edge that closes its strobe cycle
	always @(posedge clk) begin
		answer_t got;
		if (arst_n === 1'b1 && done === 1'b1) begin
			got.status = status_t'(status);
			got.slot = slot_out;
			got.lo = value_low;
			got.hi = value_high;
			sb.check_answer(got);
		end
	end

	// Inverse of an odd number modulo 2**64 by Newton steps
	function automatic logic [63:0] odd_inverse(logic [63:0] a);
		logic [63:0] x;
		x = a;
		repeat (6) x = x * (64'd2 - a * x);
		return x;
	endfunction

	function automatic logic [63:0] invert_xorshift(logic [63:0] y, int s);
		logic [63:0] x;
		x = y;
		repeat (4) x = y ^ (x >> s);
		return x;
	endfunction

	// Run the mixer backwards from a chosen hash: the key lands on the given home slot
	function automatic logic [KEY_W-1:0] key_homed_at(int unsigned home);
		logic [63:0] h;
		logic [63:0] k;
		do begin
			h = {$urandom, $urandom};
			h = (h & ~SLOT_MASK64) | 64'(home);
			k = invert_xorshift(h, 31) * inv_b;
			k = invert_xorshift(k, 27) * inv_a;
			k = invert_xorshift(k, 30);
		end while (k[63] || k == '0);
		return k[KEY_W-1:0];
	endfunction

	function automatic logic [KEY_W-1:0] rand_key();
		logic [63:0] w;
		w = {$urandom, $urandom};
		return (w[KEY_W-1:0] == '0) ? 63'd1 : w[KEY_W-1:0];
	endfunction

	function automatic request_t mk(logic pub, logic [KEY_W-1:0] k, logic [SLOT_W-1:0] s,
		logic [VAL_W-1:0] lo, logic [VAL_W-1:0] hi);
		request_t r;
		r.is_publish = pub;
		r.key = k;
		r.slot = s;
		r.lo = lo;
		r.hi = hi;
		return r;
	endfunction

	// Present a request, hold it until taken, then note the answer and track the key
	task automatic issue(input request_t r);
		int i;
		start <= 1'b1;
		req_type <= r.is_publish;
		key <= r.key;
		slot <= r.slot;
		value_in_low <= r.lo;
		value_in_high <= r.hi;
		@(posedge clk);
		while (busy !== 1'b0) @(posedge clk);
		last_answer = sb.note_request(r);
		if (last_answer.status == STAT_CLAIMED) begin
			open_key.push_back(r.key);
			open_slot.push_back(last_answer.slot);
		end else if (r.is_publish && last_answer.status == STAT_HIT) begin
			for (i = 0; i < open_key.size(); i++) begin
				if (open_key[i] == r.key) begin
					open_key.delete(i);
					open_slot.delete(i);
					break;
				end
			end
			done_key.push_back(r.key);
			done_slot.push_back(r.slot);
		end
	endtask

	task automatic pause(input int n);
		if (n > 0) begin
			start <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// Stop sending and hold until every answer is in, then let the block settle
	task automatic drain();
		start <= 1'b0;
		while (sb.answers_due.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_limit(input logic [CNT_W-1:0] v);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (cfg_ready !== 1'b1) @(posedge clk);
		sb.limit = v;
		cfg_valid <= 1'b0;
	endtask

	// Random traffic in bursts: mostly claim, publish and re-read of real keys,
	// the rest zero keys and publishes that must be refused
	task automatic random_phase(input int n);
		request_t r;
		int       burst;
		int       pick;
		int       i;
		burst = 0;
		repeat (n) begin
			if (burst == 0) begin
				burst = $urandom_range(1, 24);
				// Leave some bursts back to back so that stretches run without gaps
				if ($urandom_range(0, 3) != 0) pause($urandom_range(1, 12));
			end
			burst--;
			r = mk(1'b0, rand_key(), SLOT_W'($urandom_range(0, SLOTS - 1)),
				{$urandom, $urandom}, {$urandom, $urandom});
			pick = $urandom_range(0, 99);
			if (pick < 6) begin
				r.key = '0;
			end else if (pick < 14) begin
				r.is_publish = 1'b1;
				case ($urandom_range(0, 3))
					0: r.key = '0;
					1: ;
					2: begin
						if (done_key.size() != 0) begin
							i = $urandom_range(0, done_key.size() - 1);
							r.key = done_key[i];
							r.slot = done_slot[i];
						end
					end
					default: begin
						if (open_key.size() != 0) begin
							i = $urandom_range(0, open_key.size() - 1);
							r.key = open_key[i];
							r.slot = open_slot[i] + 1'b1;
						end
					end
				endcase
			end else if (pick < 40) begin
				if (open_key.size() != 0) begin
					i = $urandom_range(0, open_key.size() - 1);
					r.is_publish = 1'b1;
					r.key = open_key[i];
					r.slot = open_slot[i];
				end
			end else if (pick < 60) begin
				if ($urandom_range(0, 1) == 1 && done_key.size() != 0) begin
					r.key = done_key[$urandom_range(0, done_key.size() - 1)];
				end else if (open_key.size() != 0) begin
					r.key = open_key[$urandom_range(0, open_key.size() - 1)];
				end
			end else if ($urandom_range(0, 2) == 0) begin
				r.key = key_homed_at(hot[$urandom_range(0, 7)]);
			end
			issue(r);
		end
	endtask

	initial begin
		logic [VAL_W-1:0] ones;
		logic [KEY_W-1:0] wrap_key [3];
		logic [SLOT_W-1:0] s_max;
		logic [SLOT_W-1:0] s_min;
		logic [SLOT_W-1:0] s_wrap;
		ones = '1;
		sb = new();
		inv_a = odd_inverse(MIX_MUL_A);
		inv_b = odd_inverse(MIX_MUL_B);
		hot[0] = SLOTS - 1;
		hot[1] = SLOTS - 2;
		for (int h = 2; h < 8; h++) hot[h] = $urandom_range(0, SLOTS - 1);

		// Drive every input from time zero, holding reset before releasing it
		arst_n = 1'b0;
		start = 1'b0;
		req_type = 1'b0;
		key = '0;
		slot = '0;
		value_in_low = '0;
		value_in_high = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// The limit port is live during the clearing sweep; requests wait on busy
		set_limit(LIMIT_MAX);

		// Zero keys on both request types
		issue(mk(1'b0, '0, '1, ones, ones));
		issue(mk(1'b1, '0, '0, ones, ones));
		// Largest key: claim, pending, refused publishes, publish, complete hit, refused republish
		issue(mk(1'b0, '1, '0, '0, '0));
		s_max = last_answer.slot;
		issue(mk(1'b0, '1, '0, '0, '0));
		issue(mk(1'b1, '1, s_max + 1'b1, ones, ones));
		issue(mk(1'b1, 63'd1, s_max, ones, ones));
		issue(mk(1'b1, '1, s_max, ones, ones));
		issue(mk(1'b0, '1, '0, '0, '0));
		issue(mk(1'b1, '1, s_max, '0, '0));
		// Smallest key with an all-zero value
		issue(mk(1'b0, 63'd1, '1, ones, ones));
		s_min = last_answer.slot;
		issue(mk(1'b1, 63'd1, s_min, '0, '0));
		issue(mk(1'b0, 63'd1, '0, ones, ones));
		// Publish to the top slot, which nobody holds
		issue(mk(1'b1, rand_key(), '1, ones, '0));

		// Three keys homed on the last slot: probing must wrap round to slots 0 and 1
		foreach (wrap_key[j]) wrap_key[j] = key_homed_at(SLOTS - 1);
		foreach (wrap_key[j]) issue(mk(1'b0, wrap_key[j], '0, '0, '0));
		issue(mk(1'b0, wrap_key[2], '0, '0, '0));
		s_wrap = sb.tag_of.exists(0) ? SLOT_W'(0) : SLOT_W'(SLOTS - 1);
		issue(mk(1'b1, wrap_key[1], open_slot[open_key.size() - 2], ones, '0));
		issue(mk(1'b0, wrap_key[1], s_wrap, '0, '0));

		// Limit equal to the count: the next new key is refused, hits still served
		drain();
		set_limit(sb.claimed);
		issue(mk(1'b0, rand_key(), '0, '0, '0));
		issue(mk(1'b0, '1, '0, '0, '0));
		drain();
		set_limit('0);
		issue(mk(1'b0, key_homed_at(SLOTS - 1), '0, '0, '0));
		issue(mk(1'b0, wrap_key[0], '0, '0, '0));

		// Random phases, each under a different limit; the second runs into it
		drain();
		set_limit(LIMIT_MAX);
		random_phase(425);
		drain();
		set_limit(sb.claimed + 27'd40);
		random_phase(425);
		drain();
		set_limit(LIMIT_HIGH);
		random_phase(425);
		drain();
		set_limit(LIMIT_RESET);
		random_phase(425);
		drain();

		$display("Run covered %0d complete hits or publishes, %0d claims, %0d pending hits,",
			sb.by_status[STAT_HIT], sb.by_status[STAT_CLAIMED], sb.by_status[STAT_PENDING]);
		$display("%0d load-limit refusals, %0d zero keys and %0d refused publishes.",
			sb.by_status[STAT_LOAD], sb.by_status[STAT_BAD_KEY], sb.by_status[STAT_BAD_PUB]);
		if (sb.errors == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule

// ===== files.f =====
sv/hmct_pkg.sv
sv/hash_memo_claim_table_core.sv
tb/sv/tb.sv
